/* src/grb_pkg.sv */
// Shared constants and types for the glyph row blitter.
package grb_pkg;

  localparam int GLYPH_ROWS  = 16;
  localparam int CHAR_CODES  = 256;
  localparam int GLYPH_COLS  = 8;
  localparam int STORE_DEPTH = 4096;

  localparam int ROW_W    = $clog2(GLYPH_ROWS);
  localparam int CODE_W   = $clog2(CHAR_CODES);
  localparam int STORE_AW = $clog2(STORE_DEPTH);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [1:0] CFG_BUFFER_BASE  = 2'd0;
  localparam logic [1:0] CFG_LAYER_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_LAYER_HEIGHT = 2'd2;

  // input item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // command word passed from front to back
  typedef struct packed {
    logic                  is_draw;
    logic [STORE_AW-1:0]   store_idx;
    logic [7:0]            store_byte;
    logic [CODE_W-1:0]     code;
    logic [7:0]            color;
    logic [31:0]           start_addr;
    logic [ROW_W-1:0]      last_idx;
    logic [GLYPH_COLS-1:0] col_mask;
  } grb_cmd_t;

endpackage

/* src/grb_front.sv */
// Front end: accepts input words, clips draws and builds commands.
module grb_front import grb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [11:0] font_index_i,
  input  logic [7:0]  font_byte_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  pen_color_i,
  input  logic [10:0] pos_x_i,
  input  logic [10:0] pos_y_i,
  input  logic [31:0] buffer_base_i,
  input  logic [11:0] layer_width_i,
  input  logic [11:0] layer_height_i,
  output logic        push_o,
  output grb_cmd_t    cmd_o,
  input  logic        q_full_i
);

  logic        hold_valid_q, hold_valid_d;
  logic        mode_q;
  logic [11:0] font_index_q;
  logic [7:0]  font_byte_q;
  logic [7:0]  char_code_q;
  logic [7:0]  pen_color_q;
  logic [10:0] pos_x_q;
  logic [10:0] pos_y_q;

  logic        accept;
  logic        clipped;
  logic        drop;
  logic        done;
  logic [11:0] wdiff;
  logic [11:0] hdiff;
  logic [22:0] prod;

  assign clipped = ({1'b0, pos_x_q} >= layer_width_i) || ({1'b0, pos_y_q} >= layer_height_i);
  assign drop    = (mode_q == MODE_DRAW) && clipped;
  assign done    = hold_valid_q && (drop || !q_full_i);
  assign push_o  = hold_valid_q && !drop && !q_full_i;

  assign in_stall_o = hold_valid_q && !done;
  assign accept     = in_valid_i && !in_stall_o;

  assign wdiff = layer_width_i - {1'b0, pos_x_q};
  assign hdiff = layer_height_i - {1'b0, pos_y_q};
  assign prod  = layer_width_i * pos_y_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.is_draw    = (mode_q == MODE_DRAW);
    cmd_o.store_idx  = font_index_q[STORE_AW-1:0];
    cmd_o.store_byte = font_byte_q;
    cmd_o.code       = char_code_q[CODE_W-1:0];
    cmd_o.color      = pen_color_q;
    cmd_o.start_addr = buffer_base_i + 32'(prod) + 32'(pos_x_q);
    if (hdiff >= 12'(GLYPH_ROWS)) begin
      cmd_o.last_idx = ROW_W'(GLYPH_ROWS - 1);
    end else begin
      cmd_o.last_idx = ROW_W'(hdiff - 12'd1);
    end
    for (int i = 0; i < GLYPH_COLS; i++) begin
      cmd_o.col_mask[i] = (wdiff > 12'(i));
    end
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (done) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q       <= mode_i;
      font_index_q <= font_index_i;
      font_byte_q  <= font_byte_i;
      char_code_q  <= char_code_i;
      pen_color_q  <= pen_color_i;
      pos_x_q      <= pos_x_i;
      pos_y_q      <= pos_y_i;
    end
  end

endmodule

/* src/grb_queue.sv */
// Short command queue between front and back.
module grb_queue import grb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  grb_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output grb_cmd_t pop_cmd_o,
  output logic     empty_o
);

  grb_cmd_t              slots_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     count_q, count_d;

  assign full_o    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* src/grb_back.sv */
// Back end: glyph store and row sequencer with output register.
module grb_back import grb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  grb_cmd_t    cmd_i,
  output logic        pop_o,
  input  logic [11:0] layer_width_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] row_address_o,
  output logic [7:0]  pixel_mask_o,
  output logic [7:0]  out_color_o,
  output logic        last_row_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [7:0] store [STORE_DEPTH];
  logic [7:0] rdata_q;

  logic [1:0]            state_q, state_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [CODE_W-1:0]     code_q;
  logic [7:0]            color_q;
  logic [31:0]           addr_q, addr_d;
  logic [ROW_W-1:0]      last_q;
  logic [GLYPH_COLS-1:0] colm_q;

  logic                  out_valid_q, out_valid_d;
  logic [31:0]           oaddr_q;
  logic [7:0]            omask_q;
  logic [7:0]            ocolor_q;
  logic                  olast_q;

  logic                  fire;
  logic                  is_last;
  logic                  wr_en;
  logic [ROW_W-1:0]      rd_row;
  logic [STORE_AW-1:0]   rd_idx;
  logic [7:0]            mask;

  assign pop_o   = (state_q == ST_IDLE) && !empty_i;
  assign wr_en   = pop_o && !cmd_i.is_draw;
  assign fire    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign is_last = (row_q == last_q);

  // next row is fetched while the current one is emitted
  assign rd_row = fire ? row_q + 1'b1 : row_q;
  assign rd_idx = STORE_AW'(STORE_AW'(code_q) * STORE_AW'(GLYPH_ROWS) + STORE_AW'(rd_row));

  always_comb begin
    for (int i = 0; i < GLYPH_COLS; i++) begin
      mask[i] = rdata_q[GLYPH_COLS-1-i] & colm_q[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (pop_o && cmd_i.is_draw) begin
          row_d   = '0;
          addr_d  = cmd_i.start_addr;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (fire) begin
          out_valid_d = 1'b1;
          row_d       = row_q + 1'b1;
          addr_d      = addr_q + 32'(layer_width_i);
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    addr_q <= addr_d;
    if (pop_o && cmd_i.is_draw) begin
      code_q  <= cmd_i.code;
      color_q <= cmd_i.color;
      last_q  <= cmd_i.last_idx;
      colm_q  <= cmd_i.col_mask;
    end
    if (fire) begin
      oaddr_q  <= addr_q;
      omask_q  <= mask;
      ocolor_q <= color_q;
      olast_q  <= is_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store[cmd_i.store_idx] <= cmd_i.store_byte;
    end
    rdata_q <= store[rd_idx];
  end

  assign out_valid_o   = out_valid_q;
  assign row_address_o = oaddr_q;
  assign pixel_mask_o  = omask_q;
  assign out_color_o   = ocolor_q;
  assign last_row_o    = olast_q;

endmodule

/* src/glyph_row_blitter_unit.sv */
// Glyph row blitter top level: config registers, front end, queue, back end.
// A draw word passes the front hold register, command queue, glyph store read and
// output register. Back end gives one row word per cycle while unstalled; a draw pops,
// reads the store, then emits a word per kept row; a font load only writes the store.
// Front end takes one word per cycle while the 4-entry command queue has room.
// Reset: async active low; config to base 0, width 320, height 200; store not cleared.
module glyph_row_blitter_unit import grb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [11:0] font_index_i,
  input  logic [7:0]  font_byte_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  pen_color_i,
  input  logic [10:0] pos_x_i,
  input  logic [10:0] pos_y_i,
  // result word channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] row_address_o,
  output logic [7:0]  pixel_mask_o,
  output logic [7:0]  out_color_o,
  output logic        last_row_o,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] buffer_base_q;
  logic [11:0] layer_width_q;
  logic [11:0] layer_height_q;

  logic     push;
  logic     q_full;
  logic     q_empty;
  logic     pop;
  grb_cmd_t push_cmd;
  grb_cmd_t pop_cmd;

  // config writes are always taken; unknown indexes are ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_base_q  <= 32'd0;
      layer_width_q  <= 12'd320;
      layer_height_q <= 12'd200;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BUFFER_BASE:  buffer_base_q  <= cfg_data_i;
        CFG_LAYER_WIDTH:  layer_width_q  <= cfg_data_i[11:0];
        CFG_LAYER_HEIGHT: layer_height_q <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  // front: holds one word, drops fully clipped draws, computes start address
  grb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .font_index_i   (font_index_i),
    .font_byte_i    (font_byte_i),
    .char_code_i    (char_code_i),
    .pen_color_i    (pen_color_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .buffer_base_i  (buffer_base_q),
    .layer_width_i  (layer_width_q),
    .layer_height_i (layer_height_q),
    .push_o         (push),
    .cmd_o          (push_cmd),
    .q_full_i       (q_full)
  );

  // loads and draws share the queue so store writes stay in order with reads
  grb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (q_empty)
  );

  // back: glyph store, row walk, registered result word
  grb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .layer_width_i (layer_width_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_address_o (row_address_o),
    .pixel_mask_o  (pixel_mask_o),
    .out_color_o   (out_color_o),
    .last_row_o    (last_row_o)
  );

endmodule
